[rtl/sgit_pkg.sv]
// Shared types and constants for the scattered grid interpolation table.
// No dependencies; used by every module of the block.
package sgit_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int MASS_W  = 16;
  localparam int ACC_W   = 18;
  localparam int ENTRY_W = 2 * MASS_W + 3 * ACC_W;

  // Divider operand widths: rounded magnitude of the product, and |den|
  localparam int DIV_DW  = 37;
  localparam int DIV_VW  = MASS_W + 1;
  localparam int DIV_CW  = $clog2(DIV_DW + 1);

  localparam logic signed [ACC_W-1:0] EST_NONE = -18'sd65536;
  localparam logic signed [ACC_W-1:0] ACC_MAX  = 18'sd131071;
  localparam logic signed [ACC_W-1:0] ACC_MIN  = 18'sh20000;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_EXACT   = 3'd2,
    ST_INTP_MN = 3'd3,
    ST_INTP_MW = 3'd4,
    ST_INTP_2D = 3'd5,
    ST_NONE    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MUL, S_DIVGO, S_DIV, S_FIN, S_DONE
  } state_t;

  // Neighbour classes kept during a scan
  localparam logic [2:0] K_SWL = 3'd0;
  localparam logic [2:0] K_SWG = 3'd1;
  localparam logic [2:0] K_SNL = 3'd2;
  localparam logic [2:0] K_SNG = 3'd3;
  localparam logic [2:0] K_QLL = 3'd4;
  localparam logic [2:0] K_QLG = 3'd5;
  localparam logic [2:0] K_QGL = 3'd6;
  localparam logic [2:0] K_QGG = 3'd7;

  localparam logic [1:0] YEAR_FIRST  = 2'd0;
  localparam logic [1:0] YEAR_SECOND = 2'd1;
  localparam logic [1:0] YEAR_THIRD  = 2'd2;

endpackage

[rtl/sgit_mem.sv]
// Point store: masses and three acceptances per entry, one write and one
// registered read port. Depends on sgit_pkg.
module sgit_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [sgit_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [sgit_pkg::ENTRY_W-1:0]  wr_data,
  input  logic [sgit_pkg::ADDR_W-1:0]   rd_addr,
  output logic [sgit_pkg::ENTRY_W-1:0]  rd_data
);

  logic [sgit_pkg::ENTRY_W-1:0] mem [sgit_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sgit_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sgit_pkg for operand widths.
module sgit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sgit_pkg::DIV_DW-1:0]   dividend,
  input  logic [sgit_pkg::DIV_VW-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [sgit_pkg::DIV_DW-1:0]   quotient
);

  logic [sgit_pkg::DIV_DW-1:0] dq;
  logic [sgit_pkg::DIV_VW-1:0] rem;
  logic [sgit_pkg::DIV_VW-1:0] dvs;
  logic [sgit_pkg::DIV_CW-1:0] cnt;
  logic [sgit_pkg::DIV_VW:0]   trial;
  logic                        fits;

  assign trial    = {rem, dq[sgit_pkg::DIV_DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dq;

  // control: count the steps, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sgit_pkg::DIV_CW'(sgit_pkg::DIV_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the dividend through, collect quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[sgit_pkg::DIV_DW-2:0], fits};
      rem <= fits ? sgit_pkg::DIV_VW'(trial - {1'b0, dvs})
                  : trial[sgit_pkg::DIV_VW-1:0];
    end
  end

endmodule

[rtl/scattered_grid_interpolation_table_top.sv]
// Top level of the scattered grid interpolation table: request sequencer,
// scan pipeline and interpolation datapath. Depends on sgit_pkg, sgit_mem
// and sgit_div.
//
// Usage: one request per input transfer on s_*, one result per request on
// m_*. An add (req_type 0) appends a point to the table or, once the table
// holds TABLE_DEPTH points, is dropped with status 1. A query (req_type 1)
// scans every stored point, one per cycle through the memory read port,
// and then interpolates with a serial divider, unless it finds an exact
// match or no neighbours to interpolate from. An add goes from S_IDLE to
// S_DONE, where its result is loaded into the output register. A query
// runs S_SCAN and S_DECIDE, then S_MUL, S_DIVGO, S_DIV and S_FIN for each
// interpolation (one, or three for the 2-D case) with the 37-step divider,
// and ends in S_DONE. One request is in work at a time; the next is taken
// once the result has moved into the output register.
// Reset empties the table (point count to zero) and drops any pending
// result. If the receiver stalls, the result is held in the output
// register and the block stops taking requests after the one in work.
module scattered_grid_interpolation_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: mass_w[15:0], mass_n[31:16], acc_first[49:32],
  //        acc_second[67:50], acc_third[85:68], zero pad[87:86]
  input  logic [87:0] s_tdata,
  // tuser: req_type[0], year_sel[2:1]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: estimate[17:0], status[20:18], zero pad[23:21]
  output logic [23:0] m_tdata
);

  localparam int MW = sgit_pkg::MASS_W;
  localparam int AW = sgit_pkg::ACC_W;

  localparam logic [2:0] K_SWL = sgit_pkg::K_SWL;
  localparam logic [2:0] K_SWG = sgit_pkg::K_SWG;
  localparam logic [2:0] K_SNL = sgit_pkg::K_SNL;
  localparam logic [2:0] K_SNG = sgit_pkg::K_SNG;
  localparam logic [2:0] K_QLL = sgit_pkg::K_QLL;
  localparam logic [2:0] K_QLG = sgit_pkg::K_QLG;
  localparam logic [2:0] K_QGL = sgit_pkg::K_QGL;
  localparam logic [2:0] K_QGG = sgit_pkg::K_QGG;

  sgit_pkg::state_t state, state_next;

  logic [sgit_pkg::CNT_W-1:0]  point_count;
  logic [sgit_pkg::CNT_W-1:0]  idx;
  logic                        in_fire;
  logic                        is_query;
  logic                        table_full;

  logic [MW-1:0] q_mw, q_mn;
  logic [1:0]    q_year;

  logic [sgit_pkg::ENTRY_W-1:0] rd_data;
  logic                         rd_v;

  // scan stage two
  logic                  s2_v, s2_exact;
  logic [2:0]            s2_cls;
  logic [2*MW:0]         s2_dist;
  logic [MW-1:0]         s2_mw, s2_mn;
  logic signed [AW-1:0]  s2_acc;

  // kept neighbours
  logic [7:0]            k_valid;
  logic [2*MW:0]         k_dist [8];
  logic [MW-1:0]         k_mw   [8];
  logic [MW-1:0]         k_mn   [8];
  logic signed [AW-1:0]  k_acc  [8];
  logic                  match_found;
  logic signed [AW-1:0]  match_acc;

  // interpolation registers
  logic [MW-1:0]          lx, lx1, lx2;
  logic signed [AW-1:0]   ly1, ly2, v1;
  logic [1:0]             lstep;
  logic                   two_d;
  logic signed [35:0]     num;
  logic signed [MW:0]     den;
  logic signed [AW-1:0]   res_est;
  sgit_pkg::status_t      res_st;

  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [sgit_pkg::DIV_DW-1:0] quo;
  logic [35:0]                 un;
  logic [MW:0]                 ud;

  assign table_full = point_count >= sgit_pkg::CNT_W'(sgit_pkg::TABLE_DEPTH);
  assign s_tready   = state == sgit_pkg::S_IDLE;
  assign in_fire    = s_tvalid && s_tready;
  assign is_query   = s_tuser[0];

  // point store
  sgit_mem u_mem (
    .clk     (clk),
    .wr_en   (in_fire && !is_query && !table_full),
    .wr_addr (point_count[sgit_pkg::ADDR_W-1:0]),
    .wr_data (s_tdata[sgit_pkg::ENTRY_W-1:0]),
    .rd_addr (idx[sgit_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // divider operands: magnitude of product plus half the divisor
  assign un = num[35] ? 36'(-num) : 36'(num);
  assign ud = den[MW] ? (MW+1)'(-den) : (MW+1)'(den);
  assign div_start = state == sgit_pkg::S_DIVGO;

  sgit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sgit_pkg::DIV_DW'(un) + sgit_pkg::DIV_DW'(ud >> 1)),
    .divisor  (ud),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sgit_pkg::S_IDLE:
        if (in_fire) begin
          state_next = is_query ? sgit_pkg::S_SCAN : sgit_pkg::S_DONE;
        end
      sgit_pkg::S_SCAN:
        if (idx == point_count && !rd_v && !s2_v) begin
          state_next = sgit_pkg::S_DECIDE;
        end
      sgit_pkg::S_DECIDE:
        if (match_found) begin
          state_next = sgit_pkg::S_DONE;
        end else if ((k_valid[K_SWL] && k_valid[K_SWG]) ||
                     (k_valid[K_SNL] && k_valid[K_SNG]) || (&k_valid[7:4])) begin
          state_next = sgit_pkg::S_MUL;
        end else begin
          state_next = sgit_pkg::S_DONE;
        end
      sgit_pkg::S_MUL:   state_next = sgit_pkg::S_DIVGO;
      sgit_pkg::S_DIVGO: state_next = sgit_pkg::S_DIV;
      sgit_pkg::S_DIV:
        if (div_done) begin
          state_next = sgit_pkg::S_FIN;
        end
      sgit_pkg::S_FIN:
        state_next = (two_d && lstep != 2'd2) ? sgit_pkg::S_MUL : sgit_pkg::S_DONE;
      sgit_pkg::S_DONE:
        if (!m_tvalid || m_tready) begin
          state_next = sgit_pkg::S_IDLE;
        end
      default: state_next = sgit_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (in_fire && !is_query && !table_full) begin
      point_count <= point_count + 1'b1;
    end
  end

  // scan address and read-valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= 1'b0;
      if (in_fire) begin
        idx <= '0;
      end else if (state == sgit_pkg::S_SCAN && idx != point_count) begin
        idx  <= idx + 1'b1;
        rd_v <= 1'b1;
      end
    end
  end

  // scan stage one: classify the entry and square its distance
  logic [MW-1:0]         p_mw, p_mn;
  logic signed [MW:0]    dw, dn;
  logic signed [2*MW+1:0] sw, sn;
  logic [2:0]            cls;
  logic signed [AW-1:0]  p_acc;

  always_comb begin
    p_mw = rd_data[MW-1:0];
    p_mn = rd_data[2*MW-1:MW];
    dw   = $signed({1'b0, p_mw}) - $signed({1'b0, q_mw});
    dn   = $signed({1'b0, p_mn}) - $signed({1'b0, q_mn});
    sw   = dw * dw;
    sn   = dn * dn;
    if (p_mw == q_mw) begin
      cls = (p_mn > q_mn) ? K_SWG : K_SWL;
    end else if (p_mn == q_mn) begin
      cls = (p_mw > q_mw) ? K_SNG : K_SNL;
    end else if (p_mn > q_mn) begin
      cls = (p_mw > q_mw) ? K_QGG : K_QLG;
    end else begin
      cls = (p_mw > q_mw) ? K_QGL : K_QLL;
    end
    case (q_year)
      sgit_pkg::YEAR_FIRST:  p_acc = $signed(rd_data[2*MW +: AW]);
      sgit_pkg::YEAR_SECOND: p_acc = $signed(rd_data[2*MW+AW +: AW]);
      sgit_pkg::YEAR_THIRD:  p_acc = $signed(rd_data[2*MW+2*AW +: AW]);
      default:               p_acc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_exact <= (p_mw == q_mw) && (p_mn == q_mn);
    s2_cls   <= cls;
    s2_dist  <= (2*MW+1)'(sw[2*MW-1:0]) + (2*MW+1)'(sn[2*MW-1:0]);
    s2_mw    <= p_mw;
    s2_mn    <= p_mn;
    s2_acc   <= p_acc;
  end

  // scan stage two: keep the first exact match and the nearest per class
  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid     <= '0;
      match_found <= 1'b0;
    end else if (in_fire) begin
      k_valid     <= '0;
      match_found <= 1'b0;
    end else if (s2_v && !match_found) begin
      if (s2_exact) begin
        match_found <= 1'b1;
      end else if (!k_valid[s2_cls] || k_dist[s2_cls] > s2_dist) begin
        k_valid[s2_cls] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && !match_found) begin
      if (s2_exact) begin
        match_acc <= s2_acc;
      end else if (!k_valid[s2_cls] || k_dist[s2_cls] > s2_dist) begin
        k_dist[s2_cls] <= s2_dist;
        k_mw[s2_cls]   <= s2_mw;
        k_mn[s2_cls]   <= s2_mn;
        k_acc[s2_cls]  <= s2_acc;
      end
    end
  end

  // rounded, signed quotient plus y1, saturated
  logic signed [AW-1:0]  lerp_res;
  logic signed [AW+21:0] qsum;

  always_comb begin
    qsum = (num[35] != den[MW]) ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
    qsum = qsum + (AW+22)'(ly1);
    if (den == '0) begin
      lerp_res = ly1;
    end else if (qsum > (AW+22)'(sgit_pkg::ACC_MAX)) begin
      lerp_res = sgit_pkg::ACC_MAX;
    end else if (qsum < (AW+22)'(sgit_pkg::ACC_MIN)) begin
      lerp_res = sgit_pkg::ACC_MIN;
    end else begin
      lerp_res = qsum[AW-1:0];
    end
  end

  // capture request, choose interpolation, run the lerp steps
  always_ff @(posedge clk) begin
    case (state)
      sgit_pkg::S_IDLE:
        if (in_fire) begin
          q_mw    <= s_tdata[MW-1:0];
          q_mn    <= s_tdata[2*MW-1:MW];
          q_year  <= s_tuser[2:1];
          res_est <= '0;
          res_st  <= table_full ? sgit_pkg::ST_FULL : sgit_pkg::ST_STORED;
          lstep   <= 2'd0;
          two_d   <= 1'b0;
        end
      sgit_pkg::S_DECIDE:
        if (match_found) begin
          res_est <= match_acc;
          res_st  <= sgit_pkg::ST_EXACT;
        end else if (k_valid[K_SWL] && k_valid[K_SWG]) begin
          lx <= q_mn; lx1 <= k_mn[K_SWL]; ly1 <= k_acc[K_SWL];
          lx2 <= k_mn[K_SWG]; ly2 <= k_acc[K_SWG];
          res_st <= sgit_pkg::ST_INTP_MN;
        end else if (k_valid[K_SNL] && k_valid[K_SNG]) begin
          lx <= q_mw; lx1 <= k_mw[K_SNL]; ly1 <= k_acc[K_SNL];
          lx2 <= k_mw[K_SNG]; ly2 <= k_acc[K_SNG];
          res_st <= sgit_pkg::ST_INTP_MW;
        end else if (&k_valid[7:4]) begin
          lx <= q_mn; lx1 <= k_mn[K_QLL]; ly1 <= k_acc[K_QLL];
          lx2 <= k_mn[K_QLG]; ly2 <= k_acc[K_QLG];
          two_d  <= 1'b1;
          res_st <= sgit_pkg::ST_INTP_2D;
        end else begin
          res_est <= sgit_pkg::EST_NONE;
          res_st  <= sgit_pkg::ST_NONE;
        end
      sgit_pkg::S_MUL: begin
        num <= ($signed({1'b0, lx}) - $signed({1'b0, lx1}))
             * ($signed({ly2[AW-1], ly2}) - $signed({ly1[AW-1], ly1}));
        den <= $signed({1'b0, lx2}) - $signed({1'b0, lx1});
      end
      sgit_pkg::S_FIN:
        if (two_d && lstep == 2'd0) begin
          v1 <= lerp_res;
          lx <= q_mn; lx1 <= k_mn[K_QGL]; ly1 <= k_acc[K_QGL];
          lx2 <= k_mn[K_QGG]; ly2 <= k_acc[K_QGG];
          lstep <= 2'd1;
        end else if (two_d && lstep == 2'd1) begin
          lx <= q_mw; lx1 <= k_mw[K_QLL]; ly1 <= v1;
          lx2 <= k_mw[K_QGL]; ly2 <= lerp_res;
          lstep <= 2'd2;
        end else begin
          res_est <= lerp_res;
        end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == sgit_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sgit_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, res_st, res_est};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= sgit_pkg::CNT_W'(sgit_pkg::TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_query && table_full) |=> $stable(point_count))
    else $error("dropped add changed the point count");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == sgit_pkg::S_DIV)
    else $error("divider running outside its wait state");
`endif

endmodule
